// ----- rtl/core/bnms_pkg.sv -----
// shared types and constants for the box non-max suppression core
// no dependencies; imported by every module under rtl/core except bnms_ram
package bnms_pkg;

    localparam int DEF_MAX_BOXES = 64;
    localparam int COORD_W       = 16;
    localparam int CLASS_W       = 10;
    localparam int SCORE_W       = 16;
    localparam int THR_W         = 17;
    localparam int CORNER_W      = 4 * COORD_W;
    localparam int LS_W          = CLASS_W + SCORE_W;
    localparam int IN_DATA_W     = 96;
    localparam int OUT_DATA_W    = 96;
    localparam int OUT_USER_W    = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int IOU_LAT       = 5;

    localparam logic [THR_W-1:0]     THR_RESET     = 17'd32768;
    localparam logic [CFG_IDX_W-1:0] REG_IOU_THR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THR = 1'b1;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_R_RD_I,
        ST_R_LD_I,
        ST_R_RD_J,
        ST_R_CMP,
        ST_R_WR,
        ST_S_RD_O,
        ST_S_RD_A,
        ST_S_LD_A,
        ST_S_CHK,
        ST_S_RD_OB,
        ST_S_RD_B,
        ST_S_IOU,
        ST_S_WAIT,
        ST_E_RD_O,
        ST_E_RD_A,
        ST_E_LD,
        ST_E_CHK,
        ST_E_END
    } t_state;

    typedef struct packed {
        logic load_we;
        logic ovf_set;
        logic sel_ord;
        logic lat_si;
        logic rank_clr;
        logic rank_acc;
        logic ord_we;
        logic lat_a;
        logic lat_box_a;
        logic lat_b;
        logic iou_start;
        logic lat_cand;
        logic push;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic skip_a;
        logic iou_done;
        logic keep;
        logic pend_valid;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/core/bnms_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module bnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/bnms_iou.sv -----
// pipelined overlap test: 65536*overlap >= thr*union with union > 0
// depends on bnms_pkg
module bnms_iou (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bnms_pkg::CORNER_W-1:0] i_box_a,
    input  logic [bnms_pkg::CORNER_W-1:0] i_box_b,
    input  logic [bnms_pkg::THR_W-1:0]    i_thr,
    output logic                          o_done,
    output logic                          o_hit
);
    import bnms_pkg::*;

    logic signed [15:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    logic signed [15:0] mnx, mxx, mny, mxy;

    logic [IOU_LAT-1:0]  r_vld;
    logic signed [16:0]  r_w, r_h, r_dxa, r_dya, r_dxb, r_dyb;
    logic signed [33:0]  r_ov2, r_aa, r_ab;
    logic signed [35:0]  r_uni;
    logic [32:0]         r_ov3, r_ov4;
    logic                r_pos;
    logic [33:0]         r_plo, r_phi;
    logic                r_hit;
    logic [51:0]         lhs, rhs;

    assign ax0 = i_box_a[15:0];
    assign ay0 = i_box_a[31:16];
    assign ax1 = i_box_a[47:32];
    assign ay1 = i_box_a[63:48];
    assign bx0 = i_box_b[15:0];
    assign by0 = i_box_b[31:16];
    assign bx1 = i_box_b[47:32];
    assign by1 = i_box_b[63:48];

    assign mnx = (ax1 < bx1) ? ax1 : bx1;
    assign mxx = (ax0 > bx0) ? ax0 : bx0;
    assign mny = (ay1 < by1) ? ay1 : by1;
    assign mxy = (ay0 > by0) ? ay0 : by0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[IOU_LAT-2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        // edge differences
        r_w   <= 17'(mnx) - 17'(mxx);
        r_h   <= 17'(mny) - 17'(mxy);
        r_dxa <= 17'(ax1) - 17'(ax0);
        r_dya <= 17'(ay1) - 17'(ay0);
        r_dxb <= 17'(bx1) - 17'(bx0);
        r_dyb <= 17'(by1) - 17'(by0);
        // areas and overlap
        r_ov2 <= (r_w < 0 || r_h < 0) ? 34'sd0 : 34'(r_w * r_h);
        r_aa  <= 34'(r_dya * r_dxa);
        r_ab  <= 34'(r_dyb * r_dxb);
        // union
        r_uni <= 36'(r_aa) + 36'(r_ab) - 36'(r_ov2);
        r_ov3 <= r_ov2[32:0];
        // threshold times union, split in two partial products
        r_pos <= (r_uni > 0);
        r_plo <= 34'(i_thr * r_uni[16:0]);
        r_phi <= 34'(i_thr * r_uni[33:17]);
        r_ov4 <= r_ov3;
        r_hit <= r_pos && (lhs >= rhs);
    end

    assign lhs = {3'b0, r_ov4, 16'b0};
    assign rhs = {1'b0, r_phi, 17'b0} + 52'(r_plo);

    assign o_done = r_vld[IOU_LAT-1];
    assign o_hit  = r_hit;

endmodule

// ----- rtl/core/bnms_datapath.sv -----
// datapath: box stores, sort order store, suppression marks, iou unit, output register
// depends on bnms_pkg, bnms_ram and bnms_iou
module bnms_datapath #(
    parameter int MAX_BOXES = bnms_pkg::DEF_MAX_BOXES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bnms_pkg::t_cmd                   i_cmd,
    output bnms_pkg::t_sts                   o_sts,
    input  logic [$clog2(MAX_BOXES)-1:0]     i_rd_idx,
    input  logic [$clog2(MAX_BOXES)-1:0]     i_wr_idx,
    input  logic [$clog2(MAX_BOXES)-1:0]     i_cur_i,
    input  logic [bnms_pkg::IN_DATA_W-1:0]   i_in_data,
    input  logic                             i_cfg_we,
    input  logic [bnms_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bnms_pkg::THR_W-1:0]       i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bnms_pkg::OUT_DATA_W-1:0]  o_out_data,
    output logic [bnms_pkg::OUT_USER_W-1:0]  o_out_user,
    output logic                             o_out_last
);
    import bnms_pkg::*;

    localparam int AW = $clog2(MAX_BOXES);

    logic [CORNER_W-1:0] corner_rdata;
    logic [LS_W-1:0]     ls_rdata, ls_wdata;
    logic [AW-1:0]       ord_rdata, box_raddr;
    logic                iou_done, iou_hit, out_free;

    logic [THR_W-1:0]     r_iou_thr, r_score_thr;
    logic [SCORE_W-1:0]   r_si, r_score_a;
    logic [AW-1:0]        r_rank, r_a, r_b;
    logic [CORNER_W-1:0]  r_corner_a, r_cand_corner, r_pend_corner;
    logic [LS_W-1:0]      r_cand_ls, r_pend_ls;
    logic                 r_pend_valid, r_out_valid, r_out_last, r_ovf;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;
    logic [MAX_BOXES-1:0] r_supp;

    // class above score in the label store
    assign ls_wdata  = {i_in_data[73:64], i_in_data[89:74]};
    assign box_raddr = i_cmd.sel_ord ? ord_rdata : i_rd_idx;

    bnms_ram #(.WIDTH(CORNER_W), .DEPTH(MAX_BOXES)) u_corner_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_we),
        .i_waddr (i_wr_idx),
        .i_wdata (i_in_data[CORNER_W-1:0]),
        .i_raddr (box_raddr),
        .o_rdata (corner_rdata)
    );

    bnms_ram #(.WIDTH(LS_W), .DEPTH(MAX_BOXES)) u_ls_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_we),
        .i_waddr (i_wr_idx),
        .i_wdata (ls_wdata),
        .i_raddr (box_raddr),
        .o_rdata (ls_rdata)
    );

    bnms_ram #(.WIDTH(AW), .DEPTH(MAX_BOXES)) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ord_we),
        .i_waddr (r_rank),
        .i_wdata (i_cur_i),
        .i_raddr (i_rd_idx),
        .o_rdata (ord_rdata)
    );

    bnms_iou u_iou (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.iou_start),
        .i_box_a (r_corner_a),
        .i_box_b (corner_rdata),
        .i_thr   (r_iou_thr),
        .o_done  (iou_done),
        .o_hit   (iou_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iou_thr   <= THR_RESET;
            r_score_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IOU_THR:   r_iou_thr   <= i_cfg_data;
                REG_SCORE_THR: r_score_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_si) begin
            r_si <= ls_rdata[SCORE_W-1:0];
        end
        if (i_cmd.rank_clr) begin
            r_rank <= '0;
        end else if (i_cmd.rank_acc) begin
            // earlier boxes win ties
            if (ls_rdata[SCORE_W-1:0] > r_si
                || (ls_rdata[SCORE_W-1:0] == r_si && i_rd_idx < i_cur_i)) begin
                r_rank <= r_rank + 1'b1;
            end
        end
        if (i_cmd.lat_a) begin
            r_a <= ord_rdata;
        end
        if (i_cmd.lat_b) begin
            r_b <= ord_rdata;
        end
        if (i_cmd.lat_box_a) begin
            r_score_a  <= ls_rdata[SCORE_W-1:0];
            r_corner_a <= corner_rdata;
        end
        if (i_cmd.lat_cand) begin
            r_cand_corner <= corner_rdata;
            r_cand_ls     <= ls_rdata;
        end
        if (i_cmd.push) begin
            r_pend_corner <= r_cand_corner;
            r_pend_ls     <= r_cand_ls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supp       <= '0;
            r_ovf        <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_supp       <= '0;
            r_ovf        <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (iou_done && iou_hit) begin
                r_supp[r_b] <= 1'b1;
            end
            if (i_cmd.ovf_set) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.push) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.push && r_pend_valid) || i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.push && r_pend_valid) || (i_cmd.finish && r_pend_valid)) begin
            r_out_data <= {6'b0, r_pend_ls[SCORE_W-1:0], r_pend_ls[LS_W-1:SCORE_W],
                           r_pend_corner};
            r_out_user <= {r_ovf, 1'b1};
            r_out_last <= i_cmd.finish;
        end else if (i_cmd.finish) begin
            // empty set marker
            r_out_data <= '0;
            r_out_user <= {r_ovf, 1'b0};
            r_out_last <= 1'b1;
        end
    end

    assign o_sts.skip_a     = (r_score_a == '0) || r_supp[r_a];
    assign o_sts.iou_done   = iou_done;
    assign o_sts.keep       = !r_supp[r_a]
                              && ({1'b0, r_cand_ls[SCORE_W-1:0]} >= r_score_thr);
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;
    assign o_out_last  = r_out_last;

endmodule

// ----- rtl/core/bnms_ctrl.sv -----
// controller: load, rank, suppression and emission sequencing
// depends on bnms_pkg
module bnms_ctrl #(
    parameter int MAX_BOXES = bnms_pkg::DEF_MAX_BOXES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_last,
    output logic                         o_in_ready,
    output bnms_pkg::t_cmd               o_cmd,
    input  bnms_pkg::t_sts               i_sts,
    output logic [$clog2(MAX_BOXES)-1:0] o_rd_idx,
    output logic [$clog2(MAX_BOXES)-1:0] o_wr_idx,
    output logic [$clog2(MAX_BOXES)-1:0] o_cur_i
);
    import bnms_pkg::*;

    localparam int AW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BOXES);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt, r_i, n_i, r_j, n_j;
    logic [CW-1:0] i_nxt, j_nxt;
    logic          use_j;
    t_cmd          cmd;

    assign i_nxt = r_i + 1'b1;
    assign j_nxt = r_j + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_i        = r_i;
        n_j        = r_j;
        cmd        = '0;
        use_j      = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_cnt < MAX_CNT) begin
                        cmd.load_we = 1'b1;
                        n_cnt       = r_cnt + 1'b1;
                    end else begin
                        cmd.ovf_set = 1'b1;
                    end
                    if (i_in_last) begin
                        n_i     = '0;
                        n_state = (n_cnt == '0) ? ST_E_END : ST_R_RD_I;
                    end
                end
            end
            // rank of box i = boxes that sort before it
            ST_R_RD_I: n_state = ST_R_LD_I;
            ST_R_LD_I: begin
                cmd.lat_si   = 1'b1;
                cmd.rank_clr = 1'b1;
                n_j          = '0;
                n_state      = ST_R_RD_J;
            end
            ST_R_RD_J: begin
                use_j   = 1'b1;
                n_state = ST_R_CMP;
            end
            ST_R_CMP: begin
                use_j        = 1'b1;
                cmd.rank_acc = 1'b1;
                if (j_nxt == r_cnt) begin
                    n_state = ST_R_WR;
                end else begin
                    n_j     = j_nxt;
                    n_state = ST_R_RD_J;
                end
            end
            ST_R_WR: begin
                cmd.ord_we = 1'b1;
                if (i_nxt == r_cnt) begin
                    n_i     = '0;
                    n_state = ST_S_RD_O;
                end else begin
                    n_i     = i_nxt;
                    n_state = ST_R_RD_I;
                end
            end
            ST_S_RD_O: n_state = ST_S_RD_A;
            ST_S_RD_A: begin
                cmd.sel_ord = 1'b1;
                cmd.lat_a   = 1'b1;
                n_state     = ST_S_LD_A;
            end
            ST_S_LD_A: begin
                cmd.lat_box_a = 1'b1;
                n_state       = ST_S_CHK;
            end
            ST_S_CHK: begin
                if (i_sts.skip_a || i_nxt == r_cnt) begin
                    if (i_nxt == r_cnt) begin
                        n_i     = '0;
                        n_state = ST_E_RD_O;
                    end else begin
                        n_i     = i_nxt;
                        n_state = ST_S_RD_O;
                    end
                end else begin
                    n_j     = i_nxt;
                    n_state = ST_S_RD_OB;
                end
            end
            ST_S_RD_OB: begin
                use_j   = 1'b1;
                n_state = ST_S_RD_B;
            end
            ST_S_RD_B: begin
                use_j       = 1'b1;
                cmd.sel_ord = 1'b1;
                cmd.lat_b   = 1'b1;
                n_state     = ST_S_IOU;
            end
            ST_S_IOU: begin
                use_j         = 1'b1;
                cmd.iou_start = 1'b1;
                n_state       = ST_S_WAIT;
            end
            ST_S_WAIT: begin
                if (i_sts.iou_done) begin
                    if (j_nxt != r_cnt) begin
                        n_j     = j_nxt;
                        n_state = ST_S_RD_OB;
                    end else if (i_nxt == r_cnt) begin
                        n_i     = '0;
                        n_state = ST_E_RD_O;
                    end else begin
                        n_i     = i_nxt;
                        n_state = ST_S_RD_O;
                    end
                end
            end
            ST_E_RD_O: n_state = ST_E_RD_A;
            ST_E_RD_A: begin
                cmd.sel_ord = 1'b1;
                cmd.lat_a   = 1'b1;
                n_state     = ST_E_LD;
            end
            ST_E_LD: begin
                cmd.lat_cand = 1'b1;
                n_state      = ST_E_CHK;
            end
            ST_E_CHK: begin
                // a held survivor goes out once the next one is known
                if (!(i_sts.keep && i_sts.pend_valid && !i_sts.out_free)) begin
                    cmd.push = i_sts.keep;
                    if (i_nxt == r_cnt) begin
                        n_state = ST_E_END;
                    end else begin
                        n_i     = i_nxt;
                        n_state = ST_E_RD_O;
                    end
                end
            end
            ST_E_END: begin
                if (i_sts.out_free) begin
                    cmd.finish = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    assign o_cmd    = cmd;
    assign o_rd_idx = use_j ? r_j[AW-1:0] : r_i[AW-1:0];
    assign o_wr_idx = r_cnt[AW-1:0];
    assign o_cur_i  = r_i[AW-1:0];

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_CNT)
        else $error("box count beyond capacity");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.push && i_sts.pend_valid) |-> i_sts.out_free)
        else $error("survivor pushed over a waiting result");

    a_iou_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.iou_start |=> (r_state == ST_S_WAIT) && !i_sts.iou_done)
        else $error("overlap test result arrived too early");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load_we || cmd.ord_we) |-> (r_cnt <= MAX_CNT) && (r_i < MAX_CNT))
        else $error("store write out of range");
`endif

endmodule

// ----- rtl/core/box_non_max_suppression_core.sv -----
// greedy non-max suppression core; boxes load at one beat per cycle until tlast
// processing of n boxes: ranking, then suppression with one overlap test per compared pair, then
// emission, which output back-pressure can stall; suppression waits on the pipelined overlap
// unit for each pair and the box stores have a single read port; one set is worked on at a time
// synchronous active-low reset returns to loading, thresholds to 0.5, count and marks clear
// box stores are not cleared; entries past the count are never read
module box_non_max_suppression_core #(
    parameter int MAX_BOXES = bnms_pkg::DEF_MAX_BOXES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // xmin, ymin, xmax, ymax, class, score, zero pad
    input  logic [bnms_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // xmin, ymin, xmax, ymax, class, score, zero pad
    output logic [bnms_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // has_box, overflowed
    output logic [bnms_pkg::OUT_USER_W-1:0]    m_axis_tuser,
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_we,
    input  logic [bnms_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bnms_pkg::THR_W-1:0]         i_cfg_data
);
    import bnms_pkg::*;

    localparam int AW = $clog2(MAX_BOXES);

    t_cmd          cmd;
    t_sts          sts;
    logic [AW-1:0] rd_idx, wr_idx, cur_i;

    bnms_ctrl #(.MAX_BOXES(MAX_BOXES)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts),
        .o_rd_idx   (rd_idx),
        .o_wr_idx   (wr_idx),
        .o_cur_i    (cur_i)
    );

    bnms_datapath #(.MAX_BOXES(MAX_BOXES)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_rd_idx    (rd_idx),
        .i_wr_idx    (wr_idx),
        .i_cur_i     (cur_i),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule
